### rtl/palette_rotate_framebuffer_writer_defines.svh
// ----------------------------------------------------------------------------
// Palette rotate framebuffer writer: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PALETTE_ROTATE_FRAMEBUFFER_WRITER_DEFINES_SVH
`define PALETTE_ROTATE_FRAMEBUFFER_WRITER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PRFW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prfw: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PRFW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prfw: next-cycle check failed");

`endif

### rtl/prfw_pkg.sv
// ----------------------------------------------------------------------------
// prfw_pkg
// Types and constants shared by the palette rotate framebuffer writer.
// ----------------------------------------------------------------------------
`default_nettype none

package prfw_pkg;

  localparam int COLOURS_PER_PALETTE = 256;
  localparam int COLOUR_W            = 8;
  localparam int ENTRY_W             = 12;
  localparam int SLOT_W              = 14;  // covers the largest palette store
  localparam int DIM_W               = 11;
  localparam int CNT_W               = 10;
  localparam int OFF_W               = 12;
  localparam int SPAN_W              = 13;
  localparam int SUM_W               = 24;
  localparam int ADDR_W              = 22;
  localparam int PAL_SEL_W           = 4;
  localparam int CFG_IDX_W           = 3;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [1:0] OP_GAMMA   = 2'd0;
  localparam logic [1:0] OP_PALETTE = 2'd1;
  localparam logic [1:0] OP_PIXEL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_H_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PAL = 3'd4;

  localparam logic [DIM_W-1:0]     RST_SRC_WIDTH  = 11'd320;
  localparam logic [DIM_W-1:0]     RST_SRC_HEIGHT = 11'd240;
  localparam logic [DIM_W-1:0]     RST_FB_HEIGHT  = 11'd400;
  localparam logic [DIM_W-1:0]     RST_H_OFFSET   = 11'h7FF;
  localparam logic [PAL_SEL_W-1:0] RST_ACTIVE_PAL = 4'd0;

  localparam logic [DIM_W-1:0] DIM_MAX = 11'd1024;

  typedef enum logic [1:0] {
    KIND_GAMMA,
    KIND_PALETTE,
    KIND_PIXEL
  } item_kind_t;

  typedef struct packed {
    item_kind_t                kind;
    logic [SLOT_W-1:0]         slot;       // gamma index, palette slot or lookup slot
    logic [COLOUR_W-1:0]       red;
    logic [COLOUR_W-1:0]       green;
    logic [COLOUR_W-1:0]       blue;
    logic signed [SPAN_W-1:0]  span;       // column plus offset
    logic [DIM_W-1:0]          height;     // clamped source height
    logic [DIM_W-1:0]          back;       // height - 1 - row
    logic                      frame_end;
    logic                      off_err;
    logic                      colour_ok;
  } queue_item_t;

endpackage

`default_nettype wire

### rtl/palette_rotate_framebuffer_writer.sv
// ----------------------------------------------------------------------------
// palette_rotate_framebuffer_writer
// Gamma-corrected palette lookup with a 90 degree rotated framebuffer address.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    operation, entry, red/green/blue
//   out      source     out_valid/out_stall  byte address, blue/green/red, flags
//   cfg      sink       cfg_we               cfg_index, cfg_wdata
//
// One beat per cycle unless in_stall or out_stall holds the flow; a pixel result
// passes the queue, s1 and the output register. Palette writes read the gamma
// table from three copies, one port each; a pixel right behind a palette write
// of the same slot is bypassed. Reset is synchronous; the memories are not
// cleared, so no wait after reset. in_stall rises only when the four-entry
// queue is full; out_stall freezes the back pipe and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_rotate_framebuffer_writer #(
  parameter int PALETTE_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [prfw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prfw_pkg::DIM_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_operation,
  input  logic [prfw_pkg::ENTRY_W-1:0]      in_entry,
  input  logic [prfw_pkg::COLOUR_W-1:0]     in_red_in,
  input  logic [prfw_pkg::COLOUR_W-1:0]     in_green_in,
  input  logic [prfw_pkg::COLOUR_W-1:0]     in_blue_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [prfw_pkg::ADDR_W-1:0]       out_byte_address,
  output logic [prfw_pkg::COLOUR_W-1:0]     out_blue_out,
  output logic [prfw_pkg::COLOUR_W-1:0]     out_green_out,
  output logic [prfw_pkg::COLOUR_W-1:0]     out_red_out,
  output logic                              out_frame_end,
  output logic                              out_offset_error
);
  import prfw_pkg::*;

  logic        push, pop, q_full, head_valid;
  queue_item_t push_item, head_item;

  prfw_front #(
    .PALETTE_COUNT (PALETTE_COUNT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_entry     (in_entry),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .push         (push),
    .push_item    (push_item)
  );

  prfw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  prfw_back #(
    .PALETTE_COUNT (PALETTE_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_item        (head_item),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_address (out_byte_address),
    .out_blue_out     (out_blue_out),
    .out_green_out    (out_green_out),
    .out_red_out      (out_red_out),
    .out_frame_end    (out_frame_end),
    .out_offset_error (out_offset_error)
  );

endmodule

`default_nettype wire

### rtl/prfw_front.sv
// ----------------------------------------------------------------------------
// prfw_front
// Config registers, beat classification, raster counters, address operands.
// ----------------------------------------------------------------------------
`default_nettype none

module prfw_front #(
  parameter int PALETTE_COUNT = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [prfw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prfw_pkg::DIM_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  input  logic [1:0]                         in_operation,
  input  logic [prfw_pkg::ENTRY_W-1:0]       in_entry,
  input  logic [prfw_pkg::COLOUR_W-1:0]      in_red_in,
  input  logic [prfw_pkg::COLOUR_W-1:0]      in_green_in,
  input  logic [prfw_pkg::COLOUR_W-1:0]      in_blue_in,
  input  logic                               q_full,
  output logic                               in_stall,
  output logic                               push,
  output prfw_pkg::queue_item_t              push_item
);
  import prfw_pkg::*;

  localparam int STORE_DEPTH = PALETTE_COUNT * COLOURS_PER_PALETTE;

  logic [DIM_W-1:0]     sw_r, sh_r, fbh_r, hoff_r;
  logic [PAL_SEL_W-1:0] active_r;
  logic [CNT_W-1:0]     col_r, row_r, col_nxt, row_nxt;

  logic                 accept, keep, col_last, row_last;
  logic [DIM_W-1:0]     sw_c, sh_c, sh_m1, back;
  logic [CNT_W-1:0]     row_c;
  logic signed [OFF_W-1:0] diff, half, off;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r     <= RST_SRC_WIDTH;
      sh_r     <= RST_SRC_HEIGHT;
      fbh_r    <= RST_FB_HEIGHT;
      hoff_r   <= RST_H_OFFSET;
      active_r <= RST_ACTIVE_PAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  sw_r     <= cfg_wdata;
        CFG_SRC_HEIGHT: sh_r     <= cfg_wdata;
        CFG_FB_HEIGHT:  fbh_r    <= cfg_wdata;
        CFG_H_OFFSET:   hoff_r   <= cfg_wdata;
        CFG_ACTIVE_PAL: active_r <= cfg_wdata[PAL_SEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    sw_c = (sw_r == '0) ? DIM_W'(1) : ((sw_r > DIM_MAX) ? DIM_MAX : sw_r);
    sh_c = (sh_r == '0) ? DIM_W'(1) : ((sh_r > DIM_MAX) ? DIM_MAX : sh_r);
    sh_m1 = sh_c - DIM_W'(1);
    // counter past a shrunk height sits on the last line
    row_c = ({1'b0, row_r} > sh_m1) ? sh_m1[CNT_W-1:0] : row_r;
    back  = sh_m1 - {1'b0, row_c};

    diff = $signed({1'b0, fbh_r}) - $signed({1'b0, sw_c});
    // halve toward zero
    half = (diff + $signed({{(OFF_W-1){1'b0}}, diff[OFF_W-1]})) >>> 1;
    off  = hoff_r[DIM_W-1] ? half : $signed({hoff_r[DIM_W-1], hoff_r});

    col_last = ({1'b0, col_r} + DIM_W'(1) >= sw_c) || (col_r == '1);
    row_last = ({1'b0, row_r} + DIM_W'(1) >= sh_c) || (row_r == '1);
  end

  always_comb begin
    push_item           = '0;
    push_item.red       = in_red_in;
    push_item.green     = in_green_in;
    push_item.blue      = in_blue_in;
    push_item.span      = $signed({3'b000, col_r}) + $signed({off[OFF_W-1], off});
    push_item.height    = sh_c;
    push_item.back      = back;
    push_item.frame_end = col_last && row_last;
    push_item.off_err   = off > diff;
    push_item.colour_ok = 32'(active_r) < PALETTE_COUNT;
    keep                = 1'b0;
    unique case (in_operation)
      OP_GAMMA: begin
        push_item.kind = KIND_GAMMA;
        push_item.slot = SLOT_W'(in_entry);
        keep           = in_entry[ENTRY_W-1:COLOUR_W] == '0;
      end
      OP_PALETTE: begin
        push_item.kind = KIND_PALETTE;
        push_item.slot = SLOT_W'(in_entry);
        keep           = 32'(in_entry) < STORE_DEPTH;
      end
      OP_PIXEL: begin
        push_item.kind = KIND_PIXEL;
        push_item.slot = SLOT_W'({active_r, in_entry[COLOUR_W-1:0]});
        keep           = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && in_operation == OP_PIXEL) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/prfw_queue.sv
// ----------------------------------------------------------------------------
// prfw_queue
// Short FIFO of classified beats between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "palette_rotate_framebuffer_writer_defines.svh"

module prfw_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  prfw_pkg::queue_item_t push_item,
  input  logic                  pop,
  output logic                  full,
  output logic                  head_valid,
  output prfw_pkg::queue_item_t head_item
);
  import prfw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  queue_item_t         slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]   count_r, count_nxt;

  assign full       = count_r == CNT_QW'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_item;
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_QW'(1);
    else if (pop && !push) count_nxt = count_r - CNT_QW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  `PRFW_ASSERT_SAME(a_q_count_bound, 1'b1, count_r <= CNT_QW'(QUEUE_DEPTH))
  `PRFW_ASSERT_NEXT(a_q_pop_only, pop && !push, count_r == $past(count_r) - CNT_QW'(1))

endmodule

`default_nettype wire

### rtl/prfw_back.sv
// ----------------------------------------------------------------------------
// prfw_back
// Gamma and palette memories, address multiply, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "palette_rotate_framebuffer_writer_defines.svh"

module prfw_back #(
  parameter int PALETTE_COUNT = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              head_valid,
  input  prfw_pkg::queue_item_t             head_item,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [prfw_pkg::ADDR_W-1:0]       out_byte_address,
  output logic [prfw_pkg::COLOUR_W-1:0]     out_blue_out,
  output logic [prfw_pkg::COLOUR_W-1:0]     out_green_out,
  output logic [prfw_pkg::COLOUR_W-1:0]     out_red_out,
  output logic                              out_frame_end,
  output logic                              out_offset_error
);
  import prfw_pkg::*;

  localparam int SA_W        = $clog2(PALETTE_COUNT) + COLOUR_W;
  localparam int STORE_DEPTH = PALETTE_COUNT * COLOURS_PER_PALETTE;
  localparam int RGB_W       = 3 * COLOUR_W;

  logic [COLOUR_W-1:0] gamma_red_mem   [COLOURS_PER_PALETTE];
  logic [COLOUR_W-1:0] gamma_green_mem [COLOURS_PER_PALETTE];
  logic [COLOUR_W-1:0] gamma_blue_mem  [COLOURS_PER_PALETTE];
  logic [RGB_W-1:0]    store_mem       [STORE_DEPTH];

  logic                advance, gam_we, pal_pop, pix_pop, store_we, byp;
  logic [SA_W-1:0]     head_slot;
  logic [SUM_W-1:0]    span_x, height_x, sum_nxt, triple;
  logic [RGB_W-1:0]    colour;

  logic [COLOUR_W-1:0] gam_red_r, gam_green_r, gam_blue_r;
  logic [RGB_W-1:0]    store_rd_r, s1_byp_data_r;
  logic                s1_valid_r, s1_byp_r, s1_fe_r, s1_oe_r, s1_ok_r;
  item_kind_t          s1_kind_r;
  logic [SA_W-1:0]     s1_slot_r;
  logic [SUM_W-1:0]    s1_sum_r;

  logic                out_valid_r, out_fe_r, out_oe_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [RGB_W-1:0]    out_rgb_r;

  // the whole back pipe moves when the output slot is free or being taken
  assign advance   = !out_valid_r || !out_stall;
  assign pop       = advance && head_valid;
  assign gam_we    = pop && head_item.kind == KIND_GAMMA;
  assign pal_pop   = pop && head_item.kind == KIND_PALETTE;
  assign pix_pop   = pop && head_item.kind == KIND_PIXEL;
  assign store_we  = advance && s1_valid_r && s1_kind_r == KIND_PALETTE;
  assign head_slot = head_item.slot[SA_W-1:0];

  // palette write committing this edge is not yet visible to the read
  assign byp = pix_pop && s1_valid_r && s1_kind_r == KIND_PALETTE && s1_slot_r == head_slot;

  always_ff @(posedge clk) begin
    if (gam_we) begin
      gamma_red_mem[head_item.slot[COLOUR_W-1:0]]   <= head_item.red;
      gamma_green_mem[head_item.slot[COLOUR_W-1:0]] <= head_item.red;
      gamma_blue_mem[head_item.slot[COLOUR_W-1:0]]  <= head_item.red;
    end
    if (pal_pop) begin
      gam_red_r   <= gamma_red_mem[head_item.red];
      gam_green_r <= gamma_green_mem[head_item.green];
      gam_blue_r  <= gamma_blue_mem[head_item.blue];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[s1_slot_r] <= {gam_red_r, gam_green_r, gam_blue_r};
    if (pix_pop)  store_rd_r <= store_mem[head_slot];
  end

  always_comb begin
    span_x   = SUM_W'(head_item.span);
    height_x = SUM_W'(head_item.height);
    sum_nxt  = span_x * height_x + SUM_W'(head_item.back);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= pop && head_item.kind != KIND_GAMMA;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind_r      <= head_item.kind;
      s1_slot_r      <= head_slot;
      s1_sum_r       <= sum_nxt;
      s1_fe_r        <= head_item.frame_end;
      s1_oe_r        <= head_item.off_err;
      s1_ok_r        <= head_item.colour_ok;
      s1_byp_r       <= byp;
      s1_byp_data_r  <= {gam_red_r, gam_green_r, gam_blue_r};
    end
  end

  always_comb begin
    triple = s1_sum_r + {s1_sum_r[SUM_W-2:0], 1'b0};
    if (!s1_ok_r)      colour = '0;
    else if (s1_byp_r) colour = s1_byp_data_r;
    else               colour = store_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && s1_kind_r == KIND_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_addr_r <= triple[ADDR_W-1:0];
      out_rgb_r  <= colour;
      out_fe_r   <= s1_fe_r;
      out_oe_r   <= s1_oe_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_address = out_addr_r;
  assign out_red_out      = out_rgb_r[RGB_W-1:2*COLOUR_W];
  assign out_green_out    = out_rgb_r[2*COLOUR_W-1:COLOUR_W];
  assign out_blue_out     = out_rgb_r[COLOUR_W-1:0];
  assign out_frame_end    = out_fe_r;
  assign out_offset_error = out_oe_r;

  `PRFW_ASSERT_SAME(a_s1_no_gamma, s1_valid_r, s1_kind_r != KIND_GAMMA)
  `PRFW_ASSERT_SAME(a_byp_pixel, s1_valid_r && s1_byp_r, s1_kind_r == KIND_PIXEL)
  `PRFW_ASSERT_NEXT(a_hold_stall, out_valid_r && out_stall, $stable(s1_valid_r))

endmodule

`default_nettype wire

### tb/sv/palette_rotate_framebuffer_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_rotate_framebuffer_writer_test
// Loads the gamma table, writes palette entries and streams pixels under
// several geometries and offsets, including clamped, centred and
// out-of-range settings. Every pixel beat is predicted in the bench (gamma
// lookup, palette store, rotated address, frame and offset flags) and each
// result beat is checked field by field, in order, under random idle and
// stall traffic and one long receiver hold-off.
// ----------------------------------------------------------------------------

module palette_rotate_framebuffer_writer_test;
  import prfw_pkg::*;

  localparam int PALETTES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_CAP = 200;
  localparam logic [1:0] OP_NONE = 2'd3;                  // ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;      // no register behind it

  typedef struct {
    logic [ADDR_W-1:0]   addr;
    logic [COLOUR_W-1:0] blue;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] red;
    logic                frame_end;
    logic                off_err;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_operation = OP_GAMMA;
  logic [ENTRY_W-1:0] in_entry = '0;
  logic [COLOUR_W-1:0] in_red_in = '0;
  logic [COLOUR_W-1:0] in_green_in = '0;
  logic [COLOUR_W-1:0] in_blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ADDR_W-1:0] out_byte_address;
  logic [COLOUR_W-1:0] out_blue_out;
  logic [COLOUR_W-1:0] out_green_out;
  logic [COLOUR_W-1:0] out_red_out;
  logic out_frame_end;
  logic out_offset_error;

  // bench copy of the block state
  logic [COLOUR_W-1:0] gamma_lut [COLOURS_PER_PALETTE];
  logic [23:0] colour_store [PALETTES*COLOURS_PER_PALETTE];
  bit colour_written [PALETTES*COLOURS_PER_PALETTE];
  logic [DIM_W-1:0] src_width_reg = RST_SRC_WIDTH;
  logic [DIM_W-1:0] src_height_reg = RST_SRC_HEIGHT;
  logic [DIM_W-1:0] fb_height_reg = RST_FB_HEIGHT;
  logic signed [DIM_W-1:0] h_offset_reg = RST_H_OFFSET;
  logic [PAL_SEL_W-1:0] active_pal_reg = RST_ACTIVE_PAL;
  int row_count = 0;
  int col_count = 0;

  pixel_result_t pending_pixels[$];
  int error_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  palette_rotate_framebuffer_writer dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_entry(in_entry),
    .in_red_in(in_red_in),
    .in_green_in(in_green_in),
    .in_blue_in(in_blue_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte_address(out_byte_address),
    .out_blue_out(out_blue_out),
    .out_green_out(out_green_out),
    .out_red_out(out_red_out),
    .out_frame_end(out_frame_end),
    .out_offset_error(out_offset_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("palette_rotate_framebuffer_writer_test failed");
      $finish;
    end
  end

  // receiver: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < REPORT_CAP)
      $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result beat with no pixel outstanding");
      end else begin
        want = pending_pixels.pop_front();
        if (out_byte_address !== want.addr)
          report_mismatch($sformatf("byte_address %0h, want %0h", out_byte_address, want.addr));
        if (out_blue_out !== want.blue)
          report_mismatch($sformatf("blue_out %0h, want %0h", out_blue_out, want.blue));
        if (out_green_out !== want.green)
          report_mismatch($sformatf("green_out %0h, want %0h", out_green_out, want.green));
        if (out_red_out !== want.red)
          report_mismatch($sformatf("red_out %0h, want %0h", out_red_out, want.red));
        if (out_frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end %b, want %b", out_frame_end, want.frame_end));
        if (out_offset_error !== want.off_err)
          report_mismatch($sformatf("offset_error %b, want %b", out_offset_error,
                                    want.off_err));
      end
    end
  end

  function automatic longint clamp_dim(input logic [DIM_W-1:0] v);
    if (v < 1)
      return 1;
    if (v > DIM_MAX)
      return DIM_MAX;
    return v;
  endfunction

  function automatic logic [COLOUR_W-1:0] rnd8();
    return COLOUR_W'($urandom);
  endfunction

  // expected pixel: palette lookup plus rotated address, then advance raster
  task automatic predict_pixel(input logic [7:0] idx);
    longint sw, sh, diff, off, addr;
    int row, col;
    bit col_last, row_last;
    logic [23:0] colour;
    pixel_result_t res;
    sw = clamp_dim(src_width_reg);
    sh = clamp_dim(src_height_reg);
    diff = longint'(fb_height_reg) - sw;
    off = longint'(h_offset_reg);
    if (off < 0)
      off = diff / 2;   // centre, truncating toward zero
    colour = colour_store[{active_pal_reg, idx}];
    row = row_count;
    col = col_count;
    col_last = (col + 1 >= sw) || (col >= 1023);
    row_last = (row + 1 >= sh) || (row >= 1023);
    if (row > sh - 1)
      row = int'(sh - 1);
    addr = ((col + off) * sh + (sh - 1 - row)) * 3;
    res.addr = addr[ADDR_W-1:0];
    res.blue = colour[7:0];
    res.green = colour[15:8];
    res.red = colour[23:16];
    res.frame_end = col_last && row_last;
    res.off_err = off > diff;
    pending_pixels.push_back(res);
    if (col_last) begin
      col_count = 0;
      row_count = row_last ? 0 : ((row_count + 1) & 1023);
    end else begin
      col_count = (col_count + 1) & 1023;
    end
  endtask

  task automatic apply_beat(input logic [1:0] op, input logic [ENTRY_W-1:0] entry,
                            input logic [7:0] r, g, b);
    case (op)
      OP_GAMMA: begin
        if (entry[11:8] == 4'h0)
          gamma_lut[entry[7:0]] = r;
      end
      OP_PALETTE: begin
        // sixteen palettes cover every 12-bit slot
        colour_store[entry] = {gamma_lut[r], gamma_lut[g], gamma_lut[b]};
        colour_written[entry] = 1'b1;
      end
      OP_PIXEL: predict_pixel(entry[7:0]);
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [1:0] op, input logic [ENTRY_W-1:0] entry,
                           input logic [7:0] r, g, b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_operation = op;
    in_entry = entry;
    in_red_in = r;
    in_green_in = g;
    in_blue_in = b;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_beat(op, entry, r, g, b);
  endtask

  // colour index written in the active palette, or -1
  function automatic int pick_colour();
    int start;
    start = $urandom_range(255);
    for (int k = 0; k < 256; k++)
      if (colour_written[{active_pal_reg, 8'((start + k) & 255)}])
        return (start + k) & 255;
    return -1;
  endfunction

  task automatic send_pixel_any();
    int idx;
    idx = pick_colour();
    if (idx < 0) begin
      idx = $urandom_range(255);
      send_beat(OP_PALETTE, {active_pal_reg, 8'(idx)}, rnd8(), rnd8(), rnd8());
    end
    send_beat(OP_PIXEL, {4'($urandom), 8'(idx)}, rnd8(), rnd8(), rnd8());
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      CFG_SRC_WIDTH: src_width_reg = data;
      CFG_SRC_HEIGHT: src_height_reg = data;
      CFG_FB_HEIGHT: fb_height_reg = data;
      CFG_H_OFFSET: h_offset_reg = data;
      CFG_ACTIVE_PAL: active_pal_reg = data[PAL_SEL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_geometry(input int w, h, fb, off, pal);
    wait_idle();
    write_reg(CFG_SRC_WIDTH, DIM_W'(w));
    write_reg(CFG_SRC_HEIGHT, DIM_W'(h));
    write_reg(CFG_FB_HEIGHT, DIM_W'(fb));
    write_reg(CFG_H_OFFSET, DIM_W'(off));
    write_reg(CFG_ACTIVE_PAL, DIM_W'(pal));
  endtask

  function automatic int rand_dim();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75)
      return $urandom_range(1, 10);
    if (pick < 85)
      return $urandom_range(0, 2047);
    case ($urandom_range(3))
      0: return 0;
      1: return 1;
      2: return 1024;
      default: return 2047;
    endcase
  endfunction

  function automatic int rand_offset();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)
      return -1;
    if (pick < 40)
      return -int'($urandom_range(1, 1024));
    if (pick < 80)
      return $urandom_range(0, 20);
    return $urandom_range(0, 1023);
  endfunction

  // every gamma entry gets a value before any palette write reads one
  task automatic test_gamma_load();
    for (int i = 0; i < COLOURS_PER_PALETTE; i++)
      send_beat(OP_GAMMA, ENTRY_W'(i), (i == 255) ? 8'hFF : (i == 0) ? 8'h00 : rnd8(),
                rnd8(), rnd8());
  endtask

  // reset geometry: 320 x 240 into 400, centred
  task automatic test_directed_pixels();
    send_beat(OP_PALETTE, 12'h000, 8'h00, 8'h00, 8'h00);
    send_beat(OP_PALETTE, 12'h0FF, 8'hFF, 8'hFF, 8'hFF);
    send_beat(OP_PIXEL, 12'hF00, 8'hFF, 8'h00, 8'hFF);
    send_beat(OP_PIXEL, 12'hFFF, 8'h00, 8'hFF, 8'h00);
    // pixel right behind a palette write of the same slot
    send_beat(OP_PALETTE, 12'h0AA, 8'hAA, 8'h55, 8'hFF);
    send_beat(OP_PIXEL, 12'h0AA, 8'h00, 8'h00, 8'h00);
    // out-of-table gamma writes are dropped
    send_beat(OP_GAMMA, 12'h100, 8'h12, 8'h34, 8'h56);
    send_beat(OP_GAMMA, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);
    // gamma entry rewritten just before a palette write reads it
    send_beat(OP_GAMMA, 12'h07E, 8'hC3, 8'h00, 8'h00);
    send_beat(OP_PALETTE, 12'h0AC, 8'h7E, 8'h00, 8'h7E);
    send_beat(OP_PIXEL, 12'h3AC, 8'h00, 8'h00, 8'h00);
    send_beat(OP_NONE, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);
    send_beat(OP_PALETTE, 12'hFFF, 8'h80, 8'h7F, 8'h01);
    send_beat(OP_PIXEL, 12'h5AA, 8'h5A, 8'hA5, 8'h5A);
    send_beat(OP_PIXEL, 12'h0FF, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_geometry_extremes();
    idle_pct = 35;
    stall_pct = 35;
    set_geometry(1, 1, 1, 0, 0);
    repeat (6) send_pixel_any();
    set_geometry(1024, 1024, 1024, -1, 1);
    repeat (24) send_pixel_any();
    // zero width clamps up, oversized height clamps down; offset too large
    set_geometry(0, 2047, 0, 1023, 2047);
    repeat (12) send_pixel_any();
    set_geometry(5, 3, 2047, -1024, 3);
    repeat (20) send_pixel_any();
    // negative centre value: address goes below zero and wraps
    set_geometry(7, 4, 3, -1, 15);
    repeat (30) send_pixel_any();
    set_geometry(2, 1024, 1023, 1023, 0);
    write_reg(CFG_SPARE, 11'h7FF);
    repeat (8) send_pixel_any();
    set_geometry(320, 240, 400, -1, 0);
    repeat (10) send_pixel_any();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    wait_idle();
    idle_pct = 0;
    stall_pct = 0;
    set_geometry(6, 5, 12, -1, 2);
    hold_left = 150;
    repeat (40) send_pixel_any();
  endtask

  task automatic run_traffic(input int iterations);
    int pick;
    logic [ENTRY_W-1:0] slot;
    logic [7:0] k;
    for (int n = 0; n < iterations; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_pixel_any();
      end else if (pick < 65) begin
        slot = {active_pal_reg, rnd8()};
        send_beat(OP_PALETTE, slot, rnd8(), rnd8(), rnd8());
        send_beat(OP_PIXEL, {4'($urandom), slot[7:0]}, rnd8(), rnd8(), rnd8());
      end else if (pick < 75) begin
        send_beat(OP_PALETTE, ENTRY_W'($urandom), rnd8(), rnd8(), rnd8());
      end else if (pick < 83) begin
        k = rnd8();
        slot = {active_pal_reg, rnd8()};
        send_beat(OP_GAMMA, {4'h0, k}, rnd8(), rnd8(), rnd8());
        send_beat(OP_PALETTE, slot, k, rnd8(), k);
        send_beat(OP_PIXEL, {4'($urandom), slot[7:0]}, rnd8(), rnd8(), rnd8());
      end else if (pick < 90) begin
        send_beat(OP_GAMMA, ENTRY_W'($urandom), rnd8(), rnd8(), rnd8());
      end else if (pick < 94) begin
        send_beat(OP_NONE, ENTRY_W'($urandom), rnd8(), rnd8(), rnd8());
      end else begin
        repeat ($urandom_range(2, 12)) send_pixel_any();
      end
    end
  endtask

  task automatic test_random_traffic();
    int idle_table [4] = '{0, 80, 0, 35};
    int stall_table [4] = '{0, 0, 80, 35};
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      idle_pct = idle_table[p];
      stall_pct = stall_table[p];
      repeat (4) begin
        set_geometry(rand_dim(), rand_dim(),
                     ($urandom_range(1) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 2047),
                     rand_offset(), $urandom_range(0, 2047));
        run_traffic(42);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_gamma_load();
    test_directed_pixels();
    test_geometry_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("palette_rotate_framebuffer_writer_test passed");
    end else begin
      $display("palette_rotate_framebuffer_writer_test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/prfw_pkg.sv
rtl/prfw_front.sv
rtl/prfw_queue.sv
rtl/prfw_back.sv
rtl/palette_rotate_framebuffer_writer.sv
tb/sv/palette_rotate_framebuffer_writer_test.sv
